// ===== sv/mseg_pkg.sv =====
// shared constants, types and helpers for the envelope generator
`timescale 1ns / 1ps

package mseg_pkg;

	localparam int PHASE_COUNT = 8;
	localparam int LAST_PHASE  = PHASE_COUNT - 1;
	localparam int PHASE_W     = 3;
	localparam int LEVEL_W     = 8;
	localparam int TIME_W      = 32;
	localparam int IVL_W       = 24;
	localparam int DUR_W       = 7;
	localparam int MS_W        = 7;
	localparam int PROD_W      = DUR_W + MS_W;
	localparam int US_PER_MS   = 1000;
	localparam int LEVEL_MAX   = 255;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;
	localparam int DIV_STEPS   = IVL_W;
	localparam int DIV_CNT_W   = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_END_LEVELS  = 3'd0,
		REG_DURATIONS   = 3'd1,
		REG_SUSTAIN     = 3'd2,
		REG_MS_PER_STEP = 3'd3,
		REG_LOOP_EN     = 3'd4,
		REG_INVERT      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [PHASE_COUNT*LEVEL_W-1:0] end_levels;
		logic [PHASE_COUNT*DUR_W-1:0]   durations;
		logic [PHASE_COUNT-1:0]         sustain;
		logic [MS_W-1:0]                ms_per_step;
		logic                           loop_en;
		logic                           invert;
	} cfg_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level_out;
		logic               active;
		logic [PHASE_W-1:0] phase_out;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_SCALE,
		ST_DIV,
		ST_RESULT
	} state_t;

	function automatic logic [LEVEL_W-1:0] end_level(input cfg_t c, input logic [PHASE_W-1:0] ph);
		return c.end_levels[ph*LEVEL_W +: LEVEL_W];
	endfunction

	function automatic logic [DUR_W-1:0] duration(input cfg_t c, input logic [PHASE_W-1:0] ph);
		return c.durations[ph*DUR_W +: DUR_W];
	endfunction

endpackage

// ===== sv/mseg_if.sv =====
// valid/ready channel interfaces for tick input and level output
`timescale 1ns / 1ps

interface mseg_in_if import mseg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] now_us;
	logic              trigger;

	modport source (output valid, output now_us, output trigger, input ready);
	modport sink (input valid, input now_us, input trigger, output ready);
endinterface

interface mseg_out_if import mseg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] level_out;
	logic               active;
	logic [PHASE_W-1:0] phase_out;

	modport source (output valid, output level_out, output active, output phase_out, input ready);
	modport sink (input valid, input level_out, input active, input phase_out, output ready);
endinterface

// ===== sv/mseg_cfg_regs.sv =====
// configuration register bank
`timescale 1ns / 1ps

module mseg_cfg_regs import mseg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_END_LEVELS:  cfg_q.end_levels  <= cfg_wdata[PHASE_COUNT*LEVEL_W-1:0];
				REG_DURATIONS:   cfg_q.durations   <= cfg_wdata[PHASE_COUNT*DUR_W-1:0];
				REG_SUSTAIN:     cfg_q.sustain     <= cfg_wdata[PHASE_COUNT-1:0];
				REG_MS_PER_STEP: cfg_q.ms_per_step <= cfg_wdata[MS_W-1:0];
				REG_LOOP_EN:     cfg_q.loop_en     <= cfg_wdata[0];
				REG_INVERT:      cfg_q.invert      <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/mseg_divider.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module mseg_divider import mseg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [IVL_W-1:0]   dividend,
	input  logic [LEVEL_W-1:0] divisor,
	output logic               done,
	output logic [IVL_W-1:0]   quotient
);

	logic [IVL_W-1:0]     quo_q;
	logic [LEVEL_W-1:0]   rem_q;
	logic [LEVEL_W-1:0]   div_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [LEVEL_W:0]     trial;
	logic [LEVEL_W:0]     trial_sub;
	logic                 fits;

	// shift in next dividend bit, subtract when the divisor fits
	assign trial     = {rem_q, quo_q[IVL_W-1]};
	assign fits      = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[IVL_W-2:0], fits};
			rem_q <= fits ? trial_sub[LEVEL_W-1:0] : trial[LEVEL_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/mseg_core.sv =====
// envelope state and the sequencer that evaluates it once per tick, stepping it when a step is due
`timescale 1ns / 1ps

module mseg_core import mseg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [TIME_W-1:0]  now_us,
	input  logic               trigger,
	output res_t               res,
	output logic               res_valid,
	input  logic               res_take,
	output logic               div_start,
	output logic [IVL_W-1:0]   div_dividend,
	output logic [LEVEL_W-1:0] div_divisor,
	input  logic               div_done,
	input  logic [IVL_W-1:0]   div_quotient
);

	state_t              state_q, state_d;
	logic                run_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [TIME_W-1:0]   last_q;
	logic [IVL_W-1:0]    ivl_q;
	logic                down_q;
	logic [TIME_W-1:0]   now_q;
	logic                trig_q;
	logic [PROD_W-1:0]   prod_q;

	// tick evaluation
	logic [TIME_W-1:0]   elapsed;
	logic                step_due;
	logic [LEVEL_W-1:0]  to_lvl;
	logic [LEVEL_W-1:0]  adv_level;
	logic                adv_reached;
	logic                ev_begin;
	logic                ev_run;
	logic                ev_touch_last;
	logic [PHASE_W-1:0]  ev_phase;
	logic [LEVEL_W-1:0]  ev_level;

	// phase start
	logic [IVL_W-1:0]    t_scaled;
	logic                same_lvl;
	logic                go_down;

	assign elapsed  = now_q - last_q;
	assign step_due = elapsed >= TIME_W'(ivl_q);
	assign to_lvl   = end_level(cfg, phase_q);

	always_comb begin
		if (!down_q) begin
			if (level_q >= to_lvl) begin
				adv_level   = level_q;
				adv_reached = 1'b1;
			end else begin
				adv_level   = level_q + 1'b1;
				adv_reached = (level_q + 1'b1) >= to_lvl;
			end
		end else begin
			if (level_q <= to_lvl) begin
				adv_level   = level_q;
				adv_reached = 1'b1;
			end else begin
				adv_level   = level_q - 1'b1;
				adv_reached = (level_q - 1'b1) <= to_lvl;
			end
		end
	end

	always_comb begin
		ev_begin      = 1'b0;
		ev_run        = run_q;
		ev_touch_last = 1'b0;
		ev_phase      = phase_q;
		ev_level      = level_q;
		if (run_q) begin
			if (step_due) begin
				ev_touch_last = 1'b1;
				ev_level      = adv_level;
				// hold on a sustained phase while the gate stays high
				if (adv_reached && (!cfg.sustain[phase_q] || !trig_q)) begin
					if (phase_q >= PHASE_W'(LAST_PHASE)) begin
						if (cfg.loop_en && trig_q) begin
							ev_begin = 1'b1;
							ev_phase = '0;
						end else begin
							ev_run = 1'b0;
						end
					end else begin
						ev_begin = 1'b1;
						ev_phase = phase_q + 1'b1;
					end
				end
			end
		end else if (trig_q) begin
			ev_begin      = 1'b1;
			ev_phase      = '0;
			ev_run        = 1'b1;
			ev_touch_last = 1'b1;
		end
		if (ev_begin && ev_phase == '0) begin
			ev_level = '0;
		end
	end

	// phase time in us, then interval = time / distance
	assign t_scaled = IVL_W'(prod_q) * IVL_W'(US_PER_MS);
	assign same_lvl = to_lvl == level_q;
	assign go_down  = to_lvl < level_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_EVAL;
			ST_EVAL:   state_d = ev_begin ? ST_MUL : ST_RESULT;
			ST_MUL:    state_d = ST_SCALE;
			ST_SCALE:  state_d = same_lvl ? ST_RESULT : ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_RESULT;
			ST_RESULT: if (res_take) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = state_q == ST_IDLE;
		res_valid    = state_q == ST_RESULT;
		div_start    = (state_q == ST_SCALE) && !same_lvl;
		div_dividend = t_scaled;
		div_divisor  = go_down ? (level_q - to_lvl) : (to_lvl - level_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			run_q   <= 1'b0;
			level_q <= '0;
			phase_q <= '0;
			last_q  <= '0;
			ivl_q   <= '0;
			down_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_EVAL: begin
					run_q   <= ev_run;
					level_q <= ev_level;
					phase_q <= ev_phase;
					if (ev_touch_last) begin
						last_q <= now_q;
					end
				end
				ST_SCALE: begin
					if (same_lvl) begin
						ivl_q <= t_scaled;
					end else begin
						down_q <= go_down;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						ivl_q <= div_quotient;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			now_q  <= now_us;
			trig_q <= trigger;
		end
		if (state_q == ST_MUL) begin
			prod_q <= PROD_W'(duration(cfg, phase_q)) * PROD_W'(cfg.ms_per_step);
		end
	end

	assign res.level_out = cfg.invert ? (LEVEL_W'(LEVEL_MAX) - level_q) : level_q;
	assign res.active    = run_q;
	assign res.phase_out = phase_q;

endmodule

// ===== sv/multi_segment_envelope_generator.sv =====
// top level: config bank, sequencer, divider and output register
//
//  channel  | dir | handshake   | payload
//  ---------+-----+-------------+----------------------------------------
//  in_ch    | in  | valid/ready | now_us[31:0], trigger
//  out_ch   | out | valid/ready | level_out[7:0], active, phase_out[2:0]
//  cfg      | in  | cfg_we      | cfg_index[2:0], cfg_wdata[63:0]
//
// a tick passes through the states idle, eval and result; when a phase starts it
// also passes mul and scale, and with a nonzero level distance also div, where
// it waits for the 24-step divider to raise done;
// one tick at a time; the output register lets the next tick enter while a
// result still waits on out_ch.ready, a second waiting result stalls the core
// arst_n clears the envelope and sequencer state, the config bank and the valid flags to zero
`timescale 1ns / 1ps

module multi_segment_envelope_generator import mseg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mseg_in_if.sink               in_ch,
	mseg_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t               cfg;
	res_t               res;
	logic               res_valid;
	logic               res_take;
	logic               div_start;
	logic [IVL_W-1:0]   div_dividend;
	logic [LEVEL_W-1:0] div_divisor;
	logic               div_done;
	logic [IVL_W-1:0]   div_quotient;
	logic               out_valid_q;
	res_t               out_q;

	mseg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	mseg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quotient)
	);

	mseg_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_ch.valid),
		.in_ready     (in_ch.ready),
		.now_us       (in_ch.now_us),
		.trigger      (in_ch.trigger),
		.res          (res),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_quotient (div_quotient)
	);

	// output register loads when empty or being drained
	assign res_take = res_valid && (!out_valid_q || out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.level_out = out_q.level_out;
	assign out_ch.active    = out_q.active;
	assign out_ch.phase_out = out_q.phase_out;

endmodule

// ===== sv/mseg_checker.sv =====
// port-level checks for the envelope generator and their bind
`timescale 1ns / 1ps

module mseg_checker import mseg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [LEVEL_W-1:0] level_out,
	input logic               active,
	input logic [PHASE_W-1:0] phase_out
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] pend_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// items taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (in_acc && !out_acc) begin
			pend_q <= pend_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level_out) && $stable(active)
			&& $stable(phase_out))
		else $error("output item changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second item taken while one is in work");

	a_no_extra_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("output item without a pending input item");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many items in flight");

endmodule

bind multi_segment_envelope_generator mseg_checker u_mseg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.level_out (out_ch.level_out),
	.active    (out_ch.active),
	.phase_out (out_ch.phase_out)
);

// ===== tb/sv/multi_segment_envelope_generator_chk.sv =====
// envelope checker: mirrors config writes, predicts each tick result, compares on out_ch
`timescale 1ns / 1ps

module multi_segment_envelope_generator_chk import mseg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	mseg_in_if                    in_ch,
	mseg_out_if                   out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    mismatches,
	output int                    outstanding
);

	cfg_t               shadow;
	bit                 running;
	bit [LEVEL_W-1:0]   env_level;
	bit [PHASE_W-1:0]   env_phase;
	bit [TIME_W-1:0]    last_step_us;
	bit [IVL_W-1:0]     step_ivl;
	bit                 falling;
	res_t               level_q[$];
	res_t               want;
	res_t               got;

	task automatic start_phase(input logic [PHASE_W-1:0] ph);
		logic [31:0]        span;
		logic [LEVEL_W-1:0] origin;
		logic [LEVEL_W-1:0] goal;
		env_phase = ph;
		span = 32'(shadow.durations[ph*DUR_W +: DUR_W]) * 32'(shadow.ms_per_step) * US_PER_MS;
		origin = (ph == 0) ? '0 : env_level;
		goal = shadow.end_levels[ph*LEVEL_W +: LEVEL_W];
		if (goal == origin) begin
			step_ivl = span[IVL_W-1:0];
		end else if (goal < origin) begin
			step_ivl = IVL_W'(span / 32'(origin - goal));
			falling = 1'b1;
		end else begin
			step_ivl = IVL_W'(span / 32'(goal - origin));
			falling = 1'b0;
		end
		if (ph == 0)
			env_level = '0;
	endtask

	// one step toward the phase end, reports whether the end has been reached
	task automatic nudge_level(output logic reached);
		logic [LEVEL_W-1:0] goal;
		goal = shadow.end_levels[env_phase*LEVEL_W +: LEVEL_W];
		if (!falling) begin
			if (env_level >= goal) begin
				reached = 1'b1;
			end else begin
				env_level = env_level + 1'b1;
				reached = (env_level >= goal);
			end
		end else begin
			if (env_level <= goal) begin
				reached = 1'b1;
			end else begin
				env_level = env_level - 1'b1;
				reached = (env_level <= goal);
			end
		end
	endtask

	task automatic predict_tick(input logic [TIME_W-1:0] now, input logic trig, output res_t r);
		logic [TIME_W-1:0] elapsed;
		logic              reached;
		elapsed = now - last_step_us;
		if (running) begin
			if (elapsed >= TIME_W'(step_ivl)) begin
				nudge_level(reached);
				if (reached && !(shadow.sustain[env_phase] && trig)) begin
					if (env_phase >= LAST_PHASE) begin
						if (shadow.loop_en && trig)
							start_phase('0);
						else
							running = 1'b0;
					end else begin
						start_phase(env_phase + 1'b1);
					end
				end
				last_step_us = now;
			end
		end else if (trig) begin
			env_level = '0;
			start_phase('0);
			last_step_us = now;
			running = 1'b1;
		end
		r.level_out = shadow.invert ? LEVEL_W'(LEVEL_MAX) - env_level : env_level;
		r.active = running;
		r.phase_out = env_phase;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shadow = '0;
			running = 1'b0;
			env_level = '0;
			env_phase = '0;
			last_step_us = '0;
			step_ivl = '0;
			falling = 1'b0;
			level_q.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.level_out = out_ch.level_out;
				got.active = out_ch.active;
				got.phase_out = out_ch.phase_out;
				if (level_q.size() == 0) begin
					mismatches++;
					$display("%0t: expected no result, got level %0d active %0b phase %0d",
						$time, got.level_out, got.active, got.phase_out);
				end else begin
					want = level_q.pop_front();
					if (got.level_out !== want.level_out || got.active !== want.active ||
						got.phase_out !== want.phase_out) begin
						mismatches++;
						$display("%0t: expected level %0d active %0b phase %0d, got level %0d active %0b phase %0d",
							$time, want.level_out, want.active, want.phase_out,
							got.level_out, got.active, got.phase_out);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_END_LEVELS:  shadow.end_levels = cfg_wdata[PHASE_COUNT*LEVEL_W-1:0];
					REG_DURATIONS:   shadow.durations = cfg_wdata[PHASE_COUNT*DUR_W-1:0];
					REG_SUSTAIN:     shadow.sustain = cfg_wdata[PHASE_COUNT-1:0];
					REG_MS_PER_STEP: shadow.ms_per_step = cfg_wdata[MS_W-1:0];
					REG_LOOP_EN:     shadow.loop_en = cfg_wdata[0];
					REG_INVERT:      shadow.invert = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				predict_tick(in_ch.now_us, in_ch.trigger, want);
				level_q.push_back(want);
			end
			outstanding = level_q.size();
		end
	end

endmodule

// ===== tb/sv/multi_segment_envelope_generator_tb.sv =====
// testbench top: clock, reset, config phases, tick stimulus and verdict
`timescale 1ns / 1ps

module multi_segment_envelope_generator_tb;
	import mseg_pkg::*;

	localparam int SETTLE = 40;
	localparam int ITEMS_PER_SET = 325;
	localparam int SET_COUNT = 6;
	localparam int PAUSE_EVERY = 150;
	localparam int DIR_N = 20;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(REG_INVERT) + 1'b1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    mismatches;
	int                    outstanding;
	int                    send_gap_pct;
	int                    recv_gap_pct;
	bit                    gate_high;
	int                    gate_left;
	logic [TIME_W-1:0]     now_stamp;

	logic [TIME_W-1:0] dir_now [DIR_N] = '{
		32'd0, 32'd0, 32'd5, 32'd5, 32'd5, 32'd1004, 32'd1005, 32'd3000, 32'd4000, 32'd5000,
		32'd6000, 32'd6000, 32'd6000, 32'd6000, 32'd6000, 32'd6000, 32'd6000,
		32'hFFFF_FFFF, 32'd3, 32'hFFFF_FFFF};
	logic dir_trig [DIR_N] = '{
		1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

	mseg_in_if  tick_ch();
	mseg_out_if level_ch();

	multi_segment_envelope_generator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (tick_ch),
		.out_ch    (level_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	multi_segment_envelope_generator_chk envelope_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (tick_ch),
		.out_ch      (level_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		level_ch.ready <= ($urandom_range(0, 99) >= recv_gap_pct);
	end

	initial begin
		#4_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// bits above the register width carry junk, the block must drop them
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val,
		input int w);
		logic [CFG_DATA_W-1:0] mask;
		mask = (w >= CFG_DATA_W) ? '1 : ((CFG_DATA_W'(1) << w) - 1'b1);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= ({$urandom(), $urandom()} & ~mask) | (val & mask);
		@(negedge clk);
	endtask

	task automatic load_settings(input cfg_t c);
		write_reg(CFG_SPARE, {$urandom(), $urandom()}, CFG_DATA_W);
		write_reg(REG_END_LEVELS, CFG_DATA_W'(c.end_levels), PHASE_COUNT*LEVEL_W);
		write_reg(REG_DURATIONS, CFG_DATA_W'(c.durations), PHASE_COUNT*DUR_W);
		write_reg(REG_SUSTAIN, CFG_DATA_W'(c.sustain), PHASE_COUNT);
		write_reg(REG_MS_PER_STEP, CFG_DATA_W'(c.ms_per_step), MS_W);
		write_reg(REG_LOOP_EN, CFG_DATA_W'(c.loop_en), 1);
		write_reg(REG_INVERT, CFG_DATA_W'(c.invert), 1);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(input logic [TIME_W-1:0] stamp, input logic gate);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.now_us <= stamp;
		tick_ch.trigger <= gate;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// hold the sender off until every predicted result has come back
	task automatic drain();
		tick_ch.valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// gate held in runs, high more often than low, with the odd one-tick glitch
	function automatic logic next_gate();
		if (gate_left == 0) begin
			gate_high = ($urandom_range(0, 99) < 65);
			gate_left = $urandom_range(1, 40);
		end
		gate_left--;
		if ($urandom_range(0, 99) < 4)
			return !gate_high;
		return gate_high;
	endfunction

	function automatic logic [TIME_W-1:0] next_delta(input int unsigned span);
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return '0;
		if (pick < 15)
			return $urandom();
		if (pick < 40)
			return $urandom_range(0, span / 16);
		return $urandom_range(0, span);
	endfunction

	// end levels drift a little from phase to phase so envelopes finish in few ticks
	function automatic cfg_t compact_settings();
		cfg_t c;
		int   lv;
		int   ph;
		lv = 0;
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			lv = lv + int'($urandom_range(0, 40)) - 15;
			if (lv < 0)
				lv = 0;
			if (lv > LEVEL_MAX)
				lv = LEVEL_MAX;
			c.end_levels[ph*LEVEL_W +: LEVEL_W] = LEVEL_W'(lv);
			c.durations[ph*DUR_W +: DUR_W] = DUR_W'($urandom_range(0, 4));
		end
		c.sustain = PHASE_COUNT'($urandom());
		c.ms_per_step = MS_W'($urandom_range(0, 3));
		c.loop_en = 1'($urandom_range(0, 1));
		c.invert = 1'($urandom_range(0, 1));
		return c;
	endfunction

	task automatic run_random(input int count, input int unsigned span);
		int i;
		for (i = 0; i < count; i++) begin
			if (i > 0 && i % PAUSE_EVERY == 0)
				drain();
			now_stamp = now_stamp + next_delta(span);
			send_tick(now_stamp, next_gate());
		end
	endtask

	initial begin
		cfg_t        setting;
		int          p;
		int          k;
		int unsigned span;
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.now_us = '0;
		tick_ch.trigger = 1'b0;
		level_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		send_gap_pct = 14;
		recv_gap_pct = 77;
		gate_high = 1'b0;
		gate_left = 0;
		now_stamp = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// short walk: odd end, zero distance with sustain, zero time, stop, wrap
		setting = '0;
		setting.end_levels = 64'h0000_0000_0001_0303;
		setting.durations = 56'h8080;
		setting.sustain = 8'b0000_0010;
		setting.ms_per_step = 7'd1;
		setting.loop_en = 1'b1;
		load_settings(setting);
		for (k = 0; k < DIR_N; k++)
			send_tick(dir_now[k], dir_trig[k]);
		drain();

		for (p = 0; p < SET_COUNT; p++) begin
			case (p / 2)
				0: begin
					send_gap_pct = 14;
					recv_gap_pct = 77;
				end
				1: begin
					send_gap_pct = 77;
					recv_gap_pct = 14;
				end
				default: begin
					send_gap_pct = 0;
					recv_gap_pct = 0;
				end
			endcase
			case (p)
				1: begin
					setting.end_levels = 64'h00FF_00FF_00FF_00FF;
					setting.durations = '1;
					setting.sustain = '1;
					setting.ms_per_step = '1;
					setting.loop_en = 1'b1;
					setting.invert = 1'b1;
					span = 200_000;
				end
				2: begin
					setting = '0;
					span = 1_000;
				end
				4: begin
					setting.end_levels = {$urandom(), $urandom()};
					setting.durations = 56'({$urandom(), $urandom()});
					setting.sustain = PHASE_COUNT'($urandom());
					setting.ms_per_step = MS_W'($urandom());
					setting.loop_en = 1'($urandom());
					setting.invert = 1'($urandom());
					span = 4_000_000;
				end
				default: begin
					setting = compact_settings();
					span = 6_000;
				end
			endcase
			load_settings(setting);
			now_stamp = $urandom();
			run_random(ITEMS_PER_SET, span);
			drain();
		end

		tick_ch.valid <= 1'b0;
		for (k = 0; k < 20_000 && outstanding != 0; k++)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/mseg_pkg.sv
sv/mseg_if.sv
sv/mseg_cfg_regs.sv
sv/mseg_divider.sv
sv/mseg_core.sv
sv/multi_segment_envelope_generator.sv
sv/mseg_checker.sv
tb/sv/multi_segment_envelope_generator_chk.sv
tb/sv/multi_segment_envelope_generator_tb.sv
